// ----- hdl/ufr_pkg.sv -----
// shared types and constants for the uart frame receiver
package ufr_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIT_PERIOD  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DATA_BITS   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PARITY_MODE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_BITS   = 3'd3;

   localparam logic [15:0] BIT_PERIOD_RESET  = 16'd2604;
   localparam logic [3:0]  DATA_BITS_RESET   = 4'd8;
   localparam logic [1:0]  PARITY_MODE_RESET = 2'd0;
   localparam logic [1:0]  STOP_BITS_RESET   = 2'd1;

   localparam logic [3:0] DATA_BITS_MIN = 4'd5;
   localparam logic [3:0] DATA_BITS_MAX = 4'd8;

   localparam logic [1:0] PARITY_NONE = 2'd0;
   localparam logic [1:0] PARITY_ODD  = 2'd1;
   localparam logic [1:0] PARITY_EVEN = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_PARITY    = 2'd1;
   localparam logic [1:0] STATUS_FRAMING   = 2'd2;

   typedef struct packed {
      logic [15:0] bit_period;
      logic [3:0]  data_bits;
      logic [1:0]  parity_mode;
      logic [1:0]  stop_bits;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] frame_status;
   } result_type;

endpackage

// ----- hdl/ufr_csr.sv -----
// configuration registers of the uart frame receiver
module ufr_csr
   import ufr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BIT_PERIOD:  cfg_in.bit_period  = csr_data;
            CSR_DATA_BITS:   cfg_in.data_bits   = csr_data[3:0];
            CSR_PARITY_MODE: cfg_in.parity_mode = csr_data[1:0];
            CSR_STOP_BITS:   cfg_in.stop_bits   = csr_data[1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period  <= BIT_PERIOD_RESET;
         cfg_ff.data_bits   <= DATA_BITS_RESET;
         cfg_ff.parity_mode <= PARITY_MODE_RESET;
         cfg_ff.stop_bits   <= STOP_BITS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/ufr_frame.sv -----
// frame state machine: bit timing, data shift, parity and stop checks
module ufr_frame
   import ufr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       sample_valid,
   input  logic       line_level,
   output logic       result_valid,
   output result_type result
);

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_START  = 3'd1;
   localparam logic [2:0] PH_DATA   = 3'd2;
   localparam logic [2:0] PH_PARITY = 3'd3;
   localparam logic [2:0] PH_STOP1  = 3'd4;
   localparam logic [2:0] PH_STOP2  = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_ff, shift_in;
   logic        ones_ff, ones_in;
   logic        parity_bad_ff, parity_bad_in;
   logic        stop_bad_ff, stop_bad_in;

   logic [15:0] tick_next;
   logic [15:0] target;
   logic [3:0]  eff_bits;
   logic [3:0]  bit_index_next;
   logic        total;
   logic        parity_on;

   always_comb begin
      priority if (cfg.data_bits < DATA_BITS_MIN) eff_bits = DATA_BITS_MIN;
      else if (cfg.data_bits > DATA_BITS_MAX)     eff_bits = DATA_BITS_MAX;
      else                                        eff_bits = cfg.data_bits;
   end

   assign parity_on      = (cfg.parity_mode == PARITY_ODD) || (cfg.parity_mode == PARITY_EVEN);
   assign tick_next      = tick_ff + 16'd1;
   // start bit is rechecked at half a bit period
   assign target         = (phase_ff == PH_START) ? {1'b0, cfg.bit_period[15:1]}
                                                  : cfg.bit_period;
   assign bit_index_next = bit_index_ff + 4'd1;
   assign total          = ones_ff ^ line_level;

   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      ones_in       = ones_ff;
      parity_bad_in = parity_bad_ff;
      stop_bad_in   = stop_bad_ff;
      result_valid  = 1'b0;
      result.data_byte    = shift_ff;
      result.frame_status = STATUS_OK;

      if (sample_valid) begin
         if (phase_ff == PH_IDLE || phase_ff > PH_STOP2) begin
            phase_in = PH_IDLE;
            if (!line_level) begin
               phase_in      = PH_START;
               tick_in       = '0;
               bit_index_in  = '0;
               shift_in      = '0;
               ones_in       = 1'b0;
               parity_bad_in = 1'b0;
               stop_bad_in   = 1'b0;
            end
         end else if (tick_next < target) begin
            tick_in = tick_next;
         end else begin
            tick_in = '0;
            unique case (phase_ff)
               PH_START: begin
                  phase_in = line_level ? PH_IDLE : PH_DATA;
               end
               PH_DATA: begin
                  shift_in     = shift_ff | (8'(line_level) << bit_index_ff[2:0]);
                  ones_in      = total;
                  bit_index_in = bit_index_next;
                  if (bit_index_next >= eff_bits)
                     phase_in = parity_on ? PH_PARITY : PH_STOP1;
               end
               PH_PARITY: begin
                  unique case (cfg.parity_mode)
                     PARITY_ODD:  parity_bad_in = !total;
                     PARITY_EVEN: parity_bad_in = total;
                     default:     parity_bad_in = 1'b0;
                  endcase
                  phase_in = PH_STOP1;
               end
               default: begin
                  // both stop slots: a low stop sample is a framing error
                  stop_bad_in = stop_bad_ff | !line_level;
                  if (phase_ff == PH_STOP1 && cfg.stop_bits >= 2'd2) begin
                     phase_in = PH_STOP2;
                  end else begin
                     phase_in     = PH_IDLE;
                     result_valid = 1'b1;
                     priority if (stop_bad_in) result.frame_status = STATUS_FRAMING;
                     else if (parity_bad_ff)   result.frame_status = STATUS_PARITY;
                     else                      result.frame_status = STATUS_OK;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_ff       <= '0;
         bit_index_ff  <= '0;
         shift_ff      <= '0;
         ones_ff       <= 1'b0;
         parity_bad_ff <= 1'b0;
         stop_bad_ff   <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
         ones_ff       <= ones_in;
         parity_bad_ff <= parity_bad_in;
         stop_bad_ff   <= stop_bad_in;
      end
   end

endmodule

// ----- hdl/ufr_out_queue.sv -----
// result register with one skid entry behind it
module ufr_out_queue
   import ufr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_in = push_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTH
   // skid entry is only used behind a waiting result
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a beat while the output register is empty");

   assert property (@(posedge clock) disable iff (reset) !(push && skid_valid_ff))
      else $error("result pushed while both entries are full");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && out_ff == $past(out_ff)))
      else $error("stalled result beat lost or changed");
`endif

endmodule

// ----- hdl/uart_frame_receiver.sv -----
// top level of the uart frame receiver
// Asynchronous serial receiver taking one receive line sample per beat on the
// req_ channel, one beat per clock while req_stall is low. Each sample updates
// the frame state machine in the cycle it is accepted; a completed frame is
// shown on the rsp_ channel with the data bits and a status (ok, parity
// error, framing error). Results go through an output register backed by one
// skid entry, so sampling continues while a result waits; req_stall rises only
// when both entries hold a result that has not been taken. Configuration is
// written through the csr_ port, which is always ready.
module uart_frame_receiver
   import ufr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_line_level,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_data_byte,
   output logic [1:0]                 rsp_frame_status,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type    cfg;
   logic       sample_valid;
   logic       result_valid;
   result_type result;
   result_type rsp_data;
   logic       queue_full;

   assign csr_ready    = 1'b1;
   assign req_stall    = queue_full;
   assign sample_valid = req_valid && !queue_full;

   ufr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ufr_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .sample_valid (sample_valid),
      .line_level   (req_line_level),
      .result_valid (result_valid),
      .result       (result)
   );

   ufr_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_data_byte    = rsp_data.data_byte;
   assign rsp_frame_status = rsp_data.frame_status;

endmodule
